// ===== rtl/sce_pkg.sv =====
// Shared types, widths and table-building functions for the sigmoid
// cross-entropy cost and gradient block. No dependencies.
package sce_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 512;
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned ACT_W             = 16;
  localparam int unsigned TGT_W             = 13;
  localparam int unsigned GRAD_W            = 14;
  localparam int unsigned COST_W            = 32;
  localparam int unsigned SIG_W             = 13;
  localparam int unsigned SP_W              = 16;
  localparam int unsigned FRAC_W            = 16;
  localparam logic [TGT_W-1:0] ONE_Q12      = 13'd4096;

  // Input word
  typedef struct packed {
    logic signed [ACT_W-1:0] activation;
    logic [TGT_W-1:0]        target_prob;
    logic                    last_element;
  } sce_in_t;

  // Result word
  typedef struct packed {
    logic signed [GRAD_W-1:0] gradient;
    logic [COST_W-1:0]        cost_sum;
    logic                     cost_valid;
  } sce_out_t;

  // Classified item held in the queue (table index travels alongside)
  typedef struct packed {
    logic signed [ACT_W-1:0] activation;
    logic [TGT_W-1:0]        target_prob;
    logic                    last_element;
    logic [FRAC_W-1:0]       frac;
  } sce_item_t;

  // One interpolation knot of both tables
  typedef struct packed {
    logic [SP_W-1:0]  sp;
    logic [SIG_W-1:0] sig;
  } knot_t;

  // Restoring divide, elaboration-time only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(w) in Q.30, 24-term series, 0 <= w <= 1
  function automatic logic [63:0] exp_series(input logic [63:0] w);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 24; n++) begin
      term = udiv64((term * w) >> 30, 64'(n));
      sum  = sum + term;
    end
    return sum;
  endfunction

  // exp(-8w) in Q.30: reciprocal then three rounded squarings
  function automatic logic [63:0] exp_neg8(input logic [63:0] w);
    logic [63:0] g;
    g = udiv64(64'd1 << 60, exp_series(w));
    for (int i = 0; i < 3; i++) begin
      g = (g * g + (64'd1 << 29)) >> 30;
    end
    return g;
  endfunction

  // ln(1+p) in Q.30 via 2*atanh(p/(2+p))
  function automatic logic [63:0] ln_one_plus(input logic [63:0] p);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] term;
    logic [63:0] sum;
    u    = udiv64(p << 30, (64'd1 << 31) + p);
    u2   = (u * u) >> 30;
    term = u;
    sum  = u;
    for (int n = 3; n <= 31; n += 2) begin
      term = (term * u2) >> 30;
      sum  = sum + udiv64(term, 64'(n));
    end
    return sum << 1;
  endfunction

  // Sigmoid and softplus knot k of a table with te intervals over -8..8
  function automatic knot_t knot_val(input int unsigned k, input int unsigned te);
    logic [63:0] mag;
    logic [63:0] w;
    logic [63:0] p;
    logic [63:0] sig;
    logic [63:0] xpos;
    logic [63:0] spv;
    knot_t       kv;
    if (2 * k >= te) begin
      mag  = 64'(2 * k - te);
    end else begin
      mag  = 64'(te - 2 * k);
    end
    w = udiv64(mag << 30, 64'(te));
    p = exp_neg8(w);
    if (2 * k >= te) begin
      sig  = udiv64(64'd1 << 60, (64'd1 << 30) + p);
      xpos = udiv64((mag * 64'd8) << 30, 64'(te));
    end else begin
      sig  = udiv64(p << 30, (64'd1 << 30) + p);
      xpos = '0;
    end
    sig    = (sig + (64'd1 << 17)) >> 18;
    spv    = (xpos + ln_one_plus(p) + (64'd1 << 17)) >> 18;
    kv.sig = sig[SIG_W-1:0];
    kv.sp  = spv[SP_W-1:0];
    return kv;
  endfunction

endpackage

// ===== rtl/sigmoid_cross_entropy_cost_grad.sv =====
// A result word passes from the queue through stage 1, stage 2 and the output register.
// Throughput: one word per cycle while out_ready is not held low, set by the
// table read and the one-word-per-cycle accumulator in the back end; a 4-entry
// queue decouples input acceptance from output stalls.
// Reset: synchronous, active low; clears the queue, pipeline valids and the
// cost accumulator. Tables are constant and need no initialisation.
module sigmoid_cross_entropy_cost_grad import sce_pkg::*; #(
  parameter int unsigned TableEntries = TABLE_ENTRIES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sce_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sce_out_t out_data
);

  localparam int unsigned IdxW   = $clog2(TableEntries + 1);
  localparam int unsigned EntryW = $bits(sce_item_t) + IdxW;

  sce_item_t        f_item, q_item;
  logic [IdxW-1:0]  f_idx, q_idx;
  logic [EntryW-1:0] q_data;
  logic             q_valid, q_ready;

  // Classify incoming words
  sce_front #(
    .TableEntries (TableEntries),
    .IdxW         (IdxW)
  ) u_front (
    .in_word (in_data),
    .item    (f_item),
    .idx     (f_idx)
  );

  // Decoupling queue
  sce_queue #(
    .Width (EntryW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  ({f_idx, f_item}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_idx  = q_data[EntryW-1 -: IdxW];
  assign q_item = q_data[$bits(sce_item_t)-1:0];

  // Arithmetic pipeline and accumulator
  sce_back #(
    .TableEntries (TableEntries),
    .IdxW         (IdxW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .q_idx     (q_idx),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/sce_front.sv =====
// Front end: saturates the target and splits the activation into a table
// index and interpolation fraction. Depends on sce_pkg.
module sce_front import sce_pkg::*; #(
  parameter int unsigned TableEntries = TABLE_ENTRIES_DEF,
  parameter int unsigned IdxW         = $clog2(TableEntries + 1)
) (
  input  sce_in_t         in_word,
  output sce_item_t       item,
  output logic [IdxW-1:0] idx
);

  logic [ACT_W-1:0]      u_off;
  logic [ACT_W+IdxW-1:0] pos;
  logic [TGT_W-1:0]      t_sat;

  // Offset binary activation, scaled onto the knot grid
  assign u_off = {~in_word.activation[ACT_W-1], in_word.activation[ACT_W-2:0]};
  assign pos   = (ACT_W + IdxW)'(u_off) * (ACT_W + IdxW)'(TableEntries);
  assign idx   = pos[FRAC_W +: IdxW];

  // Targets above one clamp to one
  assign t_sat = (in_word.target_prob > ONE_Q12) ? ONE_Q12 : in_word.target_prob;

  assign item.activation   = in_word.activation;
  assign item.target_prob  = t_sat;
  assign item.last_element = in_word.last_element;
  assign item.frac         = pos[FRAC_W-1:0];

endmodule

// ===== rtl/sce_queue.sv =====
// Short FIFO between the front end and the arithmetic back end.
// Depends on sce_pkg for the default depth.
module sce_queue import sce_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [Width-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [Width-1:0] pop_data
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] store_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CntW'(Depth));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/sce_back.sv =====
// Back end: table lookup, interpolation, gradient and saturating cost
// accumulation in a three-stage pipeline. Depends on sce_pkg.
module sce_back import sce_pkg::*; #(
  parameter int unsigned TableEntries = TABLE_ENTRIES_DEF,
  parameter int unsigned IdxW         = $clog2(TableEntries + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  sce_item_t       q_item,
  input  logic [IdxW-1:0] q_idx,
  output logic            out_valid,
  input  logic            out_ready,
  output sce_out_t        out_data
);

  // Knot tables, built at elaboration
  logic [SIG_W-1:0] sig_rom [TableEntries+1];
  logic [SP_W-1:0]  sp_rom  [TableEntries+1];

  for (genvar k = 0; k < TableEntries + 1; k++) begin : g_knot
    localparam knot_t Knot = knot_val(k, TableEntries);
    assign sig_rom[k] = Knot.sig;
    assign sp_rom[k]  = Knot.sp;
  end

  logic adv;
  logic [IdxW-1:0] idx_hi;

  // Stage 1: table read and target times activation
  logic                     v1_r;
  logic [SIG_W-1:0]         sig_lo1_r, sig_hi1_r;
  logic [SP_W-1:0]          sp_lo1_r, sp_hi1_r;
  logic [FRAC_W-1:0]        frac1_r;
  logic [TGT_W-1:0]         t1_r;
  logic                     last1_r;
  logic signed [29:0]       ta_prod1_r;

  // Stage 2: interpolation products
  logic                     v2_r;
  logic [SIG_W-1:0]         sig_base2_r;
  logic [SP_W-1:0]          sp_base2_r;
  logic signed [30:0]       sig_prod2_r;
  logic signed [33:0]       sp_prod2_r;
  logic signed [17:0]       ta2_r;
  logic [TGT_W-1:0]         t2_r;
  logic                     last2_r;

  logic signed [SIG_W:0]    d_sig;
  logic signed [SP_W:0]     d_sp;
  logic signed [29:0]       ta_rnd;

  // Stage 3: final sums into the output register
  logic signed [30:0]       sig_rnd;
  logic signed [33:0]       sp_rnd;
  logic signed [15:0]       s_val;
  logic signed [15:0]       grad_val;
  logic signed [18:0]       sp_val;
  logic signed [19:0]       elem;
  logic signed [33:0]       acc_sum;
  logic [COST_W-1:0]        acc_sat;
  logic [COST_W-1:0]        acc_r, acc_nxt;
  logic                     out_valid_r;
  sce_out_t                 out_data_r, out_data_nxt;

  // Whole pipeline moves when the output register can take a word
  assign adv     = !out_valid_r || out_ready;
  assign q_ready = adv;
  assign idx_hi  = q_idx + IdxW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else if (adv) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
      acc_r       <= acc_nxt;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (adv) begin
      sig_lo1_r  <= sig_rom[q_idx];
      sig_hi1_r  <= sig_rom[idx_hi];
      sp_lo1_r   <= sp_rom[q_idx];
      sp_hi1_r   <= sp_rom[idx_hi];
      frac1_r    <= q_item.frac;
      t1_r       <= q_item.target_prob;
      last1_r    <= q_item.last_element;
      ta_prod1_r <= $signed({1'b0, q_item.target_prob}) * $signed(q_item.activation);
    end
  end

  // Stage 2 payload
  assign d_sig  = $signed({1'b0, sig_hi1_r}) - $signed({1'b0, sig_lo1_r});
  assign d_sp   = $signed({1'b0, sp_hi1_r}) - $signed({1'b0, sp_lo1_r});
  assign ta_rnd = ta_prod1_r + 30'sd2048;

  always_ff @(posedge clk) begin
    if (adv) begin
      sig_base2_r <= sig_lo1_r;
      sp_base2_r  <= sp_lo1_r;
      sig_prod2_r <= 31'(d_sig) * $signed({1'b0, frac1_r});
      sp_prod2_r  <= 34'(d_sp) * $signed({1'b0, frac1_r});
      ta2_r       <= ta_rnd[29:12];
      t2_r        <= t1_r;
      last2_r     <= last1_r;
    end
  end

  // Stage 3: round, gradient, element cost and clamped running sum
  always_comb begin
    sig_rnd  = sig_prod2_r + 31'sd32768;
    sp_rnd   = sp_prod2_r + 34'sd32768;
    s_val    = $signed({3'b000, sig_base2_r}) + 16'($signed(sig_rnd[30:16]));
    grad_val = s_val - $signed({3'b000, t2_r});
    sp_val   = $signed({3'b000, sp_base2_r}) + 19'($signed(sp_rnd[33:16]));
    elem     = 20'(sp_val) - 20'(ta2_r);
    acc_sum  = $signed({2'b00, acc_r}) + 34'(elem);
    if (acc_sum[33]) begin
      acc_sat = '0;
    end else if (acc_sum[32]) begin
      acc_sat = '1;
    end else begin
      acc_sat = acc_sum[31:0];
    end

    acc_nxt = acc_r;
    if (v2_r) begin
      acc_nxt = last2_r ? '0 : acc_sat;
    end

    out_data_nxt.gradient   = grad_val[GRAD_W-1:0];
    out_data_nxt.cost_sum   = last2_r ? acc_sat : '0;
    out_data_nxt.cost_valid = last2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/sce_checker.sv =====
// Port-level checks for the sigmoid cross-entropy block, bound to the top
// level. Depends on sce_pkg.
module sce_checker import sce_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input sce_out_t out_data
);

  // Result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Cost field is zero unless marked valid
  a_cost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.cost_valid |-> out_data.cost_sum == '0)
    else $error("cost_sum set without cost_valid");

  // Gradient stays within minus one to one
  a_grad_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.gradient) >= -14'sd4096) &&
                  ($signed(out_data.gradient) <= 14'sd4096))
    else $error("gradient out of range");

  // Nothing presented straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sigmoid_cross_entropy_cost_grad sce_checker u_sce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/sigmoid_cross_entropy_cost_grad_test.sv =====
// Self-checking bench for sigmoid_cross_entropy_cost_grad: directed, long-vector
// and random vector tests against a built-in table-driven predictor.
// Depends on sce_pkg (word types, widths) and the block's RTL.
module sigmoid_cross_entropy_cost_grad_test import sce_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  localparam int unsigned KNOTS        = TABLE_ENTRIES_DEF;
  localparam u64_t        Q30_ONE      = 64'd1 << 30;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned SETTLE_TICKS = 10;
  localparam int unsigned RANDOM_ITEMS = 580;
  localparam int unsigned QUIET_TAIL   = 120;
  localparam int unsigned LONG_ITEMS   = 100;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sce_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sce_out_t out_data;

  // Knot values of both interpolation tables, Q.12
  longint      sig_knot [0:KNOTS];
  longint      sp_knot  [0:KNOTS];
  longint      cost_acc;
  sce_out_t    expected_results [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          sender_idle_en;
  bit          receiver_idle_en;

  sigmoid_cross_entropy_cost_grad DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Table construction (Q.30 integer arithmetic)
  // ---------------------------------------------------------------------

  // exp(w), 24-term Taylor series, 0 <= w <= 1
  function automatic u64_t exp_taylor(input u64_t w);
    u64_t sum;
    u64_t term;
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (u64_t n = 1; n <= 24; n++) begin
      term = ((term * w) >> 30) / n;
      sum  = sum + term;
    end
    return sum;
  endfunction

  // exp(-8w): reciprocal, then three rounded squarings
  function automatic u64_t exp_neg_eight(input u64_t w);
    u64_t g;
    g = (64'd1 << 60) / exp_taylor(w);
    repeat (3) g = (g * g + (64'd1 << 29)) >> 30;
    return g;
  endfunction

  // ln(1+p) as 2*atanh(p/(2+p))
  function automatic u64_t log1p_q30(input u64_t p);
    u64_t u;
    u64_t u2;
    u64_t term;
    u64_t sum;
    u    = (p << 30) / ((64'd1 << 31) + p);
    u2   = (u * u) >> 30;
    term = u;
    sum  = u;
    for (u64_t n = 3; n <= 31; n += 2) begin
      term = (term * u2) >> 30;
      sum  = sum + term / n;
    end
    return sum << 1;
  endfunction

  function automatic void build_knot_tables();
    longint num;
    u64_t   mag;
    u64_t   w;
    u64_t   p;
    u64_t   sig;
    u64_t   xpos;
    for (int k = 0; k <= KNOTS; k++) begin
      num = 2 * k - longint'(KNOTS);
      mag = u64_t'(num < 0 ? -num : num);
      w   = (mag << 30) / u64_t'(KNOTS);
      p   = exp_neg_eight(w);
      if (num >= 0) begin
        sig  = (64'd1 << 60) / (Q30_ONE + p);
        xpos = ((mag * 8) << 30) / u64_t'(KNOTS);
      end else begin
        sig  = (p << 30) / (Q30_ONE + p);
        xpos = 0;
      end
      sig_knot[k] = longint'((sig + (64'd1 << 17)) >> 18);
      sp_knot[k]  = longint'((xpos + log1p_q30(p) + (64'd1 << 17)) >> 18);
    end
  endfunction

  // Linear interpolation, half rounding up (arithmetic shift floors)
  function automatic longint interp_knot(input longint lo, input longint hi,
                                         input longint frac);
    return lo + (((hi - lo) * frac + 32768) >>> 16);
  endfunction

  // ---------------------------------------------------------------------
  // Predictor: gradient per word, saturating cost per vector
  // ---------------------------------------------------------------------
  function automatic sce_out_t predict_result(input sce_in_t w);
    longint   act;
    longint   tgt;
    longint   pos;
    longint   idx;
    longint   frac;
    longint   sig_v;
    longint   sp_v;
    longint   t_times_a;
    longint   acc;
    sce_out_t r;
    act = longint'($signed(w.activation));
    tgt = longint'(w.target_prob);
    if (tgt > longint'(ONE_Q12)) tgt = longint'(ONE_Q12);
    pos  = (act + 32768) * longint'(KNOTS);
    idx  = pos >> 16;
    frac = pos & 64'hFFFF;
    if (idx >= KNOTS) idx = KNOTS - 1;
    sig_v = interp_knot(sig_knot[idx], sig_knot[idx+1], frac);
    sp_v  = interp_knot(sp_knot[idx], sp_knot[idx+1], frac);

    r.gradient = GRAD_W'(sig_v - tgt);
    t_times_a  = (tgt * act + 2048) >>> 12;
    acc = cost_acc + sp_v - t_times_a;
    if (acc < 0) acc = 0;
    if (acc > longint'(32'hFFFF_FFFF)) acc = longint'(32'hFFFF_FFFF);

    if (w.last_element) begin
      r.cost_sum   = acc[COST_W-1:0];
      r.cost_valid = 1'b1;
      cost_acc     = 0;
    end else begin
      r.cost_sum   = '0;
      r.cost_valid = 1'b0;
      cost_acc     = acc;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------
  function automatic sce_in_t make_word(input int act, input int tgt, input bit last);
    sce_in_t w;
    w.activation   = ACT_W'(act);
    w.target_prob  = TGT_W'(tgt);
    w.last_element = last;
    return w;
  endfunction

  function automatic sce_in_t random_word(input bit last);
    sce_in_t     w;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      w.activation = ACT_W'($urandom);
    end else if (pick < 17) begin
      // near either end of the range
      w.activation = $urandom_range(0, 1) ? ACT_W'(32767 - $urandom_range(0, 255))
                                          : ACT_W'(-32768 + $urandom_range(0, 255));
    end else begin
      // on or next to a knot (spacing 128 in Q4.12)
      w.activation = ACT_W'(($urandom_range(0, 511) << 7) - 32768
                            + $urandom_range(0, 2) - 1);
    end
    pick = $urandom_range(0, 9);
    if (pick < 8)       w.target_prob = TGT_W'($urandom_range(0, 4096));
    else if (pick == 8) w.target_prob = $urandom_range(0, 1) ? ONE_Q12 : '0;
    else                w.target_prob = TGT_W'($urandom_range(4097, 8191));
    w.last_element = last;
    return w;
  endfunction

  // Present one word from a falling edge, hold until taken, log its result
  task automatic send_word(input sce_in_t w);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_result(w));
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Result-side backpressure in bursts
  always begin : ready_driver
    @(negedge clk);
    if (receiver_idle_en && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    out_ready <= 1'b1;
  end

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    sce_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: gradient %0d cost_sum %0d",
               $signed(out_data.gradient), out_data.cost_sum);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.gradient !== want.gradient) begin
          $error("gradient: expected %0d, got %0d",
                 $signed(want.gradient), $signed(out_data.gradient));
          mismatch_count++;
        end
        if (out_data.cost_sum !== want.cost_sum) begin
          $error("cost_sum: expected %0d, got %0d", want.cost_sum, out_data.cost_sum);
          mismatch_count++;
        end
        if (out_data.cost_valid !== want.cost_valid) begin
          $error("cost_valid: expected %0b, got %0b", want.cost_valid,
                 out_data.cost_valid);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sigmoid_cross_entropy_cost_grad");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes, knot points, target saturation, one-word vectors
  task automatic test_directed_edges();
    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;
    send_word(make_word(-32768, 0, 1'b1));
    send_word(make_word(32767, 4096, 1'b1));
    send_word(make_word(32767, 0, 1'b0));
    send_word(make_word(32767, 8191, 1'b0));
    send_word(make_word(0, 2048, 1'b0));
    send_word(make_word(-1, 4097, 1'b0));
    send_word(make_word(1, 1, 1'b1));
    send_word(make_word(4096, 4096, 1'b0));
    send_word(make_word(-4096, 0, 1'b0));
    send_word(make_word(128, 3000, 1'b0));
    send_word(make_word(127, 100, 1'b0));
    send_word(make_word(-32640, 4095, 1'b0));
    send_word(make_word(-32768, 4096, 1'b1));
    // near-zero costs with the accumulator empty exercise the floor clamp
    send_word(make_word(32767, 4096, 1'b0));
    send_word(make_word(32640, 4096, 1'b0));
    send_word(make_word(32704, 4096, 1'b1));
    send_word(make_word(-32768, 0, 1'b0));
    send_word(make_word(-32767, 0, 1'b1));
    send_word(make_word(16384, 6000, 1'b0));
    send_word(make_word(-16384, 8191, 1'b1));
    wait_drained();
  endtask

  // One long vector of maximal element costs builds a large running sum
  task automatic test_long_vector();
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    for (int unsigned k = 0; k < LONG_ITEMS; k++) send_word(make_word(32767, 0, 1'b0));
    send_word(make_word(-32768, 4096, 1'b0));
    send_word(make_word(32767, 0, 1'b1));
    send_word(make_word(0, 0, 1'b1));
    wait_drained();
  endtask

  // Random vectors of mostly short lengths; final stretch at full rate
  task automatic test_random_vectors();
    int unsigned sent;
    int unsigned vec_len;
    sent             = 0;
    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - QUIET_TAIL) begin
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
      end
      vec_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                            : $urandom_range(1, 24);
      if (vec_len > RANDOM_ITEMS - sent) vec_len = RANDOM_ITEMS - sent;
      for (int unsigned k = 1; k <= vec_len; k++) begin
        send_word(random_word(k == vec_len));
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    out_ready        = 1'b0;
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    cost_acc         = 0;
    build_knot_tables();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_edges();
    test_long_vector();
    test_random_vectors();

    // let everything drain, then allow for stray words
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS sigmoid_cross_entropy_cost_grad");
    end else begin
      $display("FAIL sigmoid_cross_entropy_cost_grad");
    end
    $finish;
  end

endmodule
